FILE: design/pprm_pkg.sv
// pprm_pkg: shared types, constants and format helpers for the pcm peak/rms meter
// used by every module of pcm_peak_rms_meter_core; depends on nothing
`timescale 1ns / 1ps

package pprm_pkg;

  // default buffer length limit
  localparam int unsigned MAX_SAMPLES_DEF = 65536;

  // fixed datapath widths
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned FS_W    = 16;
  localparam int unsigned FS_SQ_W = 32;
  localparam int unsigned LEVEL_W = 17;
  localparam int unsigned RQ_W    = 34;
  localparam int unsigned SREM_W  = 19;
  localparam int unsigned IT_W    = 6;

  // finishing sequence step counts
  localparam logic [IT_W-1:0] DIV_LAST   = 6'd33;
  localparam logic [IT_W-1:0] SQRT_LAST  = 6'd16;
  localparam logic [IT_W-1:0] PEAK_STEPS = 6'd17;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 17'h1FFFF;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_IS_16BIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_IS_SIGNED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN       = 2'd2;

  typedef struct packed {
    logic is16;
    logic sgn;
  } pprm_fmt_t;

  // one decoded sample in the queue
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             last;
    pprm_fmt_t        fmt;
  } pprm_entry_t;

  // buffer totals handed to the finishing unit
  typedef struct packed {
    logic [MAG_W-1:0] peak;
    logic [SUM_W-1:0] sum;
    pprm_fmt_t        fmt;
  } pprm_fin_req_t;

  typedef enum logic [2:0] {
    FIN_IDLE,
    FIN_MUL,
    FIN_CHK,
    FIN_DIV,
    FIN_SQRT,
    FIN_OUT
  } pprm_fin_state_e;

  function automatic logic [FS_W-1:0] full_scale(input pprm_fmt_t fmt);
    logic [FS_W-1:0] fs;
    unique case ({fmt.is16, fmt.sgn})
      2'b00:   fs = 16'd255;
      2'b01:   fs = 16'd127;
      2'b10:   fs = 16'd65535;
      default: fs = 16'd32767;
    endcase
    return fs;
  endfunction

  function automatic logic [FS_SQ_W-1:0] full_scale_sq(input pprm_fmt_t fmt);
    logic [FS_SQ_W-1:0] fsq;
    unique case ({fmt.is16, fmt.sgn})
      2'b00:   fsq = 32'd65025;
      2'b01:   fsq = 32'd16129;
      2'b10:   fsq = 32'd4294836225;
      default: fsq = 32'd1073676289;
    endcase
    return fsq;
  endfunction

endpackage

FILE: design/pprm_front.sv
// pprm_front: configuration registers and sample decode into magnitude
// depends on pprm_pkg; feeds pprm_queue
`timescale 1ns / 1ps

module pprm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [pprm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic                                cfg_data_i,
  output logic                                cfg_ready_o,
  input  logic                                in_valid_i,
  input  logic [7:0]                          first_byte_i,
  input  logic [7:0]                          second_byte_i,
  input  logic                                is_last_i,
  output logic                                in_stall_o,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output pprm_pkg::pprm_entry_t               q_entry_o
);

  logic is16_q, is16_d;
  logic sgn_q, sgn_d;
  logic be_q, be_d;
  logic [15:0] raw16;
  logic [15:0] mag;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    is16_d = is16_q;
    sgn_d  = sgn_q;
    be_d   = be_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pprm_pkg::REG_SAMPLE_IS_16BIT:  is16_d = cfg_data_i;
        pprm_pkg::REG_SAMPLE_IS_SIGNED: sgn_d  = cfg_data_i;
        pprm_pkg::REG_BIG_ENDIAN:       be_d   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is16_q <= 1'b1;
      sgn_q  <= 1'b1;
      be_q   <= 1'b0;
    end else begin
      is16_q <= is16_d;
      sgn_q  <= sgn_d;
      be_q   <= be_d;
    end
  end

  assign raw16 = be_q ? {first_byte_i, second_byte_i} : {second_byte_i, first_byte_i};

  // negative signed samples become their magnitude, unsigned ones stay offset
  always_comb begin
    if (is16_q) begin
      mag = (sgn_q && raw16[15]) ? 16'(~raw16 + 16'd1) : raw16;
    end else begin
      mag = (sgn_q && first_byte_i[7]) ? 16'(16'd256 - {8'd0, first_byte_i})
                                       : {8'd0, first_byte_i};
    end
  end

  assign in_stall_o     = q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i;
  assign q_entry_o.mag  = mag;
  assign q_entry_o.last = is_last_i;
  assign q_entry_o.fmt  = '{is16: is16_q, sgn: sgn_q};

endmodule

FILE: design/pprm_queue.sv
// pprm_queue: four-entry queue of decoded samples between front and back
// depends on pprm_pkg
`timescale 1ns / 1ps

module pprm_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pprm_pkg::pprm_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output pprm_pkg::pprm_entry_t entry_o
);

  pprm_pkg::pprm_entry_t mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] fill_q, fill_d;

  assign full_o  = (fill_q == 3'd4);
  assign valid_o = (fill_q != 3'd0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? 2'(wr_ptr_q + 2'd1) : wr_ptr_q;
    rd_ptr_d = pop_i ? 2'(rd_ptr_q + 2'd1) : rd_ptr_q;
    fill_d   = fill_q;
    if (push_i && !pop_i) begin
      fill_d = 3'(fill_q + 3'd1);
    end else if (!push_i && pop_i) begin
      fill_d = 3'(fill_q - 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 2'd0;
      rd_ptr_q <= 2'd0;
      fill_q   <= 3'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: design/pprm_accum.sv
// pprm_accum: squares each magnitude, keeps peak, sum of squares and count
// depends on pprm_pkg; hands buffer totals to pprm_finish
`timescale 1ns / 1ps

module pprm_accum #(
  parameter int unsigned MaxSamples = pprm_pkg::MAX_SAMPLES_DEF,
  localparam int unsigned CntW      = $clog2(MaxSamples + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    q_valid_i,
  input  pprm_pkg::pprm_entry_t   q_entry_i,
  output logic                    q_pop_o,
  input  logic                    fin_busy_i,
  output logic                    fin_start_o,
  output pprm_pkg::pprm_fin_req_t fin_req_o,
  output logic [CntW-1:0]         fin_count_o
);

  localparam logic [CntW-1:0] CountMax = CntW'(MaxSamples);

  logic                   a_valid_q, a_valid_d;
  pprm_pkg::pprm_entry_t  a_entry_q;
  logic [pprm_pkg::SQ_W-1:0] a_sq_q;

  logic [pprm_pkg::MAG_W-1:0] peak_q, peak_n;
  logic [pprm_pkg::SUM_W-1:0] sum_q, sum_n;
  logic [CntW-1:0]            cnt_q, cnt_n;
  logic                       adv;
  logic                       room;

  // a last item waits here while the previous buffer is still finishing
  assign adv     = a_valid_q && !(a_entry_q.last && fin_busy_i);
  assign q_pop_o = q_valid_i && (!a_valid_q || adv);

  always_comb begin
    a_valid_d = a_valid_q;
    if (q_pop_o) begin
      a_valid_d = 1'b1;
    end else if (adv) begin
      a_valid_d = 1'b0;
    end
  end

  // samples past the length limit are dropped entirely
  always_comb begin
    room   = (cnt_q < CountMax);
    peak_n = peak_q;
    sum_n  = sum_q;
    cnt_n  = cnt_q;
    if (room) begin
      if (a_entry_q.mag > peak_q) begin
        peak_n = a_entry_q.mag;
      end
      sum_n = 48'(sum_q + {16'd0, a_sq_q});
      cnt_n = CntW'(cnt_q + 1'b1);
    end
  end

  assign fin_start_o    = adv && a_entry_q.last;
  assign fin_req_o.peak = peak_n;
  assign fin_req_o.sum  = sum_n;
  assign fin_req_o.fmt  = a_entry_q.fmt;
  assign fin_count_o    = cnt_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      peak_q    <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
    end else begin
      a_valid_q <= a_valid_d;
      if (adv) begin
        if (a_entry_q.last) begin
          peak_q <= '0;
          sum_q  <= '0;
          cnt_q  <= '0;
        end else begin
          peak_q <= peak_n;
          sum_q  <= sum_n;
          cnt_q  <= cnt_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_entry_q <= q_entry_i;
      a_sq_q    <= 32'(q_entry_i.mag) * 32'(q_entry_i.mag);
    end
  end

endmodule

FILE: design/pprm_finish.sv
// pprm_finish: per-buffer level computation, divide then square root, and result register
// depends on pprm_pkg; fed by pprm_accum
`timescale 1ns / 1ps

module pprm_finish #(
  parameter int unsigned MaxSamples = pprm_pkg::MAX_SAMPLES_DEF,
  localparam int unsigned CntW      = $clog2(MaxSamples + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  pprm_pkg::pprm_fin_req_t             req_i,
  input  logic [CntW-1:0]                     count_i,
  output logic                                busy_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pprm_pkg::LEVEL_W-1:0]        peak_level_o,
  output logic [pprm_pkg::LEVEL_W-1:0]        rms_level_o
);

  localparam int unsigned DenW  = CntW + pprm_pkg::FS_SQ_W;
  localparam int unsigned RemW  = (DenW + 1 > pprm_pkg::SUM_W) ? DenW + 1 : pprm_pkg::SUM_W;
  localparam int unsigned RemW1 = RemW + 1;
  localparam int unsigned CmpW  = (DenW + 2 > pprm_pkg::SUM_W) ? DenW + 2 : pprm_pkg::SUM_W;

  pprm_pkg::pprm_fin_state_e st_q, st_d;

  pprm_pkg::pprm_fmt_t        fmt_q, fmt_d;
  logic [pprm_pkg::MAG_W-1:0] peak_q, peak_d;
  logic [pprm_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [DenW-1:0]            den_q, den_d;
  logic                       psat_q, psat_d;
  logic                       rsat_q, rsat_d;
  logic [pprm_pkg::FS_W-1:0]  prem_q, prem_d;
  logic [pprm_pkg::LEVEL_W-1:0] pq_q, pq_d;
  logic [RemW-1:0]            rrem_q, rrem_d;
  logic [pprm_pkg::RQ_W-1:0]  rq_q, rq_d;
  logic [pprm_pkg::IT_W-1:0]  it_q, it_d;
  logic [pprm_pkg::SREM_W-1:0] srem_q, srem_d;
  logic [pprm_pkg::LEVEL_W-1:0] root_q, root_d;
  logic [pprm_pkg::LEVEL_W-1:0] peak_lvl_q, peak_lvl_d;
  logic [pprm_pkg::LEVEL_W-1:0] rms_lvl_q, rms_lvl_d;
  logic                       out_valid_q, out_valid_d;

  logic [pprm_pkg::FS_W-1:0]  fs;
  logic                       load;
  logic                       rbit;
  logic [RemW1-1:0]           rtry;
  logic [RemW1-1:0]           rden;
  logic                       pbit;
  logic [pprm_pkg::FS_W:0]    ptry;
  logic [1:0]                 pair;
  logic [pprm_pkg::SREM_W+1:0] stry;
  logic [pprm_pkg::SREM_W+1:0] trial;

  assign fs     = pprm_pkg::full_scale(fmt_q);
  assign load   = (st_q == pprm_pkg::FIN_OUT) && (!out_valid_q || !out_stall_i);
  assign busy_o = (st_q != pprm_pkg::FIN_IDLE);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      pprm_pkg::FIN_IDLE: if (start_i) st_d = pprm_pkg::FIN_MUL;
      pprm_pkg::FIN_MUL:  st_d = pprm_pkg::FIN_CHK;
      pprm_pkg::FIN_CHK:  st_d = pprm_pkg::FIN_DIV;
      pprm_pkg::FIN_DIV:  if (it_q == pprm_pkg::DIV_LAST) st_d = pprm_pkg::FIN_SQRT;
      pprm_pkg::FIN_SQRT: if (it_q == pprm_pkg::SQRT_LAST) st_d = pprm_pkg::FIN_OUT;
      pprm_pkg::FIN_OUT:  if (load) st_d = pprm_pkg::FIN_IDLE;
      default:            st_d = pprm_pkg::FIN_IDLE;
    endcase
  end

  // dividends are peak << 16 and sum << 32; the high quotient bits are zero once
  // saturation is ruled out, so each division starts from its shifted-down remainder
  always_comb begin
    fmt_d  = fmt_q;
    peak_d = peak_q;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    psat_d = psat_q;
    rsat_d = rsat_q;
    prem_d = prem_q;
    pq_d   = pq_q;
    rrem_d = rrem_q;
    rq_d   = rq_q;
    it_d   = it_q;
    srem_d = srem_q;
    root_d = root_q;
    peak_lvl_d = peak_lvl_q;
    rms_lvl_d  = rms_lvl_q;

    rbit  = (it_q == 6'd0) ? sum_q[1] : ((it_q == 6'd1) ? sum_q[0] : 1'b0);
    rtry  = {rrem_q, rbit};
    rden  = RemW1'(den_q);
    pbit  = (it_q == 6'd0) ? peak_q[0] : 1'b0;
    ptry  = {prem_q, pbit};
    pair  = rq_q[pprm_pkg::RQ_W-1 -: 2];
    stry  = {srem_q, pair};
    trial = {2'b00, root_q, 2'b01};

    unique case (st_q)
      pprm_pkg::FIN_IDLE: begin
        if (start_i) begin
          fmt_d  = req_i.fmt;
          peak_d = req_i.peak;
          sum_d  = req_i.sum;
          cnt_d  = count_i;
        end
      end
      pprm_pkg::FIN_MUL: begin
        den_d = DenW'(cnt_q) * DenW'(pprm_pkg::full_scale_sq(fmt_q));
      end
      pprm_pkg::FIN_CHK: begin
        psat_d = ({1'b0, peak_q} >= {fs, 1'b0});
        rsat_d = (CmpW'(sum_q) >= CmpW'({den_q, 2'b00}));
        prem_d = {1'b0, peak_q[pprm_pkg::MAG_W-1:1]};
        pq_d   = '0;
        rrem_d = RemW'(sum_q >> 2);
        rq_d   = '0;
        it_d   = '0;
      end
      pprm_pkg::FIN_DIV: begin
        if (rtry >= rden) begin
          rrem_d = RemW'(rtry - rden);
          rq_d   = {rq_q[pprm_pkg::RQ_W-2:0], 1'b1};
        end else begin
          rrem_d = rtry[RemW-1:0];
          rq_d   = {rq_q[pprm_pkg::RQ_W-2:0], 1'b0};
        end
        if (it_q < pprm_pkg::PEAK_STEPS) begin
          if (ptry >= {1'b0, fs}) begin
            prem_d = 16'(ptry - {1'b0, fs});
            pq_d   = {pq_q[pprm_pkg::LEVEL_W-2:0], 1'b1};
          end else begin
            prem_d = ptry[pprm_pkg::FS_W-1:0];
            pq_d   = {pq_q[pprm_pkg::LEVEL_W-2:0], 1'b0};
          end
        end
        if (it_q == pprm_pkg::DIV_LAST) begin
          it_d   = '0;
          srem_d = '0;
          root_d = '0;
        end else begin
          it_d = 6'(it_q + 6'd1);
        end
      end
      pprm_pkg::FIN_SQRT: begin
        // one root bit per cycle from the top bit pair down
        rq_d = {rq_q[pprm_pkg::RQ_W-3:0], 2'b00};
        if (stry >= trial) begin
          srem_d = 19'(stry - trial);
          root_d = {root_q[pprm_pkg::LEVEL_W-2:0], 1'b1};
        end else begin
          srem_d = stry[pprm_pkg::SREM_W-1:0];
          root_d = {root_q[pprm_pkg::LEVEL_W-2:0], 1'b0};
        end
        it_d = 6'(it_q + 6'd1);
      end
      pprm_pkg::FIN_OUT: begin
        if (load) begin
          peak_lvl_d = psat_q ? pprm_pkg::LEVEL_MAX : pq_q;
          rms_lvl_d  = rsat_q ? pprm_pkg::LEVEL_MAX : root_q;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= pprm_pkg::FIN_IDLE;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      it_q        <= it_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fmt_q      <= fmt_d;
    peak_q     <= peak_d;
    sum_q      <= sum_d;
    cnt_q      <= cnt_d;
    den_q      <= den_d;
    psat_q     <= psat_d;
    rsat_q     <= rsat_d;
    prem_q     <= prem_d;
    pq_q       <= pq_d;
    rrem_q     <= rrem_d;
    rq_q       <= rq_d;
    srem_q     <= srem_d;
    root_q     <= root_d;
    peak_lvl_q <= peak_lvl_d;
    rms_lvl_q  <= rms_lvl_d;
  end

  assign out_valid_o  = out_valid_q;
  assign peak_level_o = peak_lvl_q;
  assign rms_level_o  = rms_lvl_q;

endmodule

FILE: design/pcm_peak_rms_meter_core.sv
// pcm_peak_rms_meter_core: top level of the pcm peak and rms level meter
// depends on pprm_pkg, pprm_front, pprm_queue, pprm_accum and pprm_finish
`timescale 1ns / 1ps

// Samples are taken one per cycle while the queue is not full, decoded to a
// magnitude and queued in a four-entry queue; the accumulator squares and
// sums one sample per cycle unless a last item waits for the finishing unit.
// An item with is_last hands the buffer totals to a finishing unit that runs
// one multiply for the divisor, one saturation check, 34 restoring-divide
// steps, 17 square-root steps and a result load that out_stall_i can hold off.
// The next buffer accumulates while that runs; its own last item waits until
// the finishing unit is free. Levels are unsigned Q1.16 relative to the full
// scale chosen at the last item and saturate at 131071. Samples past
// MaxSamples in one buffer are dropped. Configuration writes are always
// accepted and must only happen while the block is idle.

module pcm_peak_rms_meter_core #(
  parameter int unsigned MaxSamples = pprm_pkg::MAX_SAMPLES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pprm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                           cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     first_byte_i,
  input  logic [7:0]                     second_byte_i,
  input  logic                           is_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pprm_pkg::LEVEL_W-1:0]   peak_level_o,
  output logic [pprm_pkg::LEVEL_W-1:0]   rms_level_o
);

  localparam int unsigned CntW = $clog2(MaxSamples + 1);

  logic                    q_full;
  logic                    q_push;
  pprm_pkg::pprm_entry_t   q_in;
  logic                    q_valid;
  logic                    q_pop;
  pprm_pkg::pprm_entry_t   q_out;
  logic                    fin_busy;
  logic                    fin_start;
  pprm_pkg::pprm_fin_req_t fin_req;
  logic [CntW-1:0]         fin_count;

  pprm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cfg_ready_o   (cfg_ready_o),
    .in_valid_i    (in_valid_i),
    .first_byte_i  (first_byte_i),
    .second_byte_i (second_byte_i),
    .is_last_i     (is_last_i),
    .in_stall_o    (in_stall_o),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_entry_o     (q_in)
  );

  pprm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_out)
  );

  pprm_accum #(
    .MaxSamples (MaxSamples)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .fin_busy_i  (fin_busy),
    .fin_start_o (fin_start),
    .fin_req_o   (fin_req),
    .fin_count_o (fin_count)
  );

  pprm_finish #(
    .MaxSamples (MaxSamples)
  ) u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (fin_start),
    .req_i        (fin_req),
    .count_i      (fin_count),
    .busy_o       (fin_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .peak_level_o (peak_level_o),
    .rms_level_o  (rms_level_o)
  );

endmodule
